[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helper macros, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define RKD_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("rkd assertion failed");
// Condition must never be true outside reset.
`define RKD_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("rkd forbidden condition seen");
`else
`define RKD_ASSERT(label, clk, rst_n, prop)
`define RKD_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

[design/rkd_pkg.sv]
// ----------------------------------------------------------------------------
// rkd_pkg
// Shared types and constants of the rotary knob key event decoder.
// ----------------------------------------------------------------------------
package rkd_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgW  = 16;

  // Configuration register reset values
  localparam logic [CfgW-1:0] DcWindowRst  = 16'd450;
  localparam logic [CfgW-1:0] LongPressRst = 16'd1500;
  localparam logic [CfgW-1:0] MinPressRst  = 16'd15;

  // Item kinds
  typedef enum logic [1:0] {
    ACT_KEY  = 2'd0,
    ACT_ENC  = 2'd1,
    ACT_POLL = 2'd2,
    ACT_READ = 2'd3
  } rkd_action_e;

  // Reported events
  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_CLICK  = 3'd1,
    EV_DOUBLE = 3'd2,
    EV_LONG   = 3'd3,
    EV_RIGHT  = 3'd4,
    EV_LEFT   = 3'd5
  } rkd_event_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_DC_WINDOW  = 2'd0,
    REG_LONG_PRESS = 2'd1,
    REG_MIN_PRESS  = 2'd2
  } rkd_reg_e;

  // Encoder phase codes; the spare code is never entered
  localparam logic [1:0] PHASE_IDLE  = 2'd0;
  localparam logic [1:0] PHASE_B_HI  = 2'd1;
  localparam logic [1:0] PHASE_B_LO  = 2'd2;
  localparam logic [1:0] PHASE_SPARE = 2'd3;

  // Configuration values seen by the decoder
  typedef struct packed {
    logic [CfgW-1:0] dc_window;
    logic [CfgW-1:0] long_press;
    logic [CfgW-1:0] min_press;
  } rkd_cfg_t;

  // One registered input transaction
  typedef struct packed {
    rkd_action_e      action;
    logic [TimeW-1:0] now_ms;
    logic             key_level;
    logic             a_level;
    logic             b_level;
  } rkd_item_t;

endpackage

[design/rkd_cfg_regs.sv]
// ----------------------------------------------------------------------------
// rkd_cfg_regs
// Timing configuration registers, written through a plain write port.
// ----------------------------------------------------------------------------
module rkd_cfg_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [rkd_pkg::CfgW-1:0]  cfg_wdata_i,
  output rkd_pkg::rkd_cfg_t         cfg_o
);

  rkd_pkg::rkd_cfg_t cfg_q, cfg_d;

  // Decode the register index; unused index drops the write
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        rkd_pkg::REG_DC_WINDOW:  cfg_d.dc_window  = cfg_wdata_i;
        rkd_pkg::REG_LONG_PRESS: cfg_d.long_press = cfg_wdata_i;
        rkd_pkg::REG_MIN_PRESS:  cfg_d.min_press  = cfg_wdata_i;
        default:                 cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dc_window  <= rkd_pkg::DcWindowRst;
      cfg_q.long_press <= rkd_pkg::LongPressRst;
      cfg_q.min_press  <= rkd_pkg::MinPressRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[design/rkd_core.sv]
// ----------------------------------------------------------------------------
// rkd_core
// Key and encoder state with the combinational event decode of one transaction.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rkd_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  rkd_pkg::rkd_item_t   item_i,
  input  rkd_pkg::rkd_cfg_t    cfg_i,
  output rkd_pkg::rkd_event_e  event_o
);

  rkd_pkg::rkd_event_e            pend_q, pend_d;
  logic [rkd_pkg::TimeW-1:0]      press_q, press_d;
  logic                           dmark_q, dmark_d;
  logic [1:0]                     phase_q, phase_d;

  logic [rkd_pkg::TimeW-1:0]      held;
  logic [rkd_pkg::TimeW-1:0]      ahead;
  logic [rkd_pkg::TimeW-1:0]      win_ext;
  logic [rkd_pkg::TimeW-1:0]      long_ext;
  logic [rkd_pkg::TimeW-1:0]      min_ext;
  logic                           do_key;
  logic                           do_enc;
  logic                           click_held;
  rkd_pkg::rkd_event_e            pend_k;
  rkd_pkg::rkd_event_e            res;

  // Elapsed time since the last press, both directions
  assign held     = item_i.now_ms - press_q;
  assign ahead    = press_q - item_i.now_ms;
  assign win_ext  = {{(rkd_pkg::TimeW-rkd_pkg::CfgW){1'b0}}, cfg_i.dc_window};
  assign long_ext = {{(rkd_pkg::TimeW-rkd_pkg::CfgW){1'b0}}, cfg_i.long_press};
  assign min_ext  = {{(rkd_pkg::TimeW-rkd_pkg::CfgW){1'b0}}, cfg_i.min_press};

  assign do_key = (item_i.action == rkd_pkg::ACT_KEY) ||
                  (item_i.action == rkd_pkg::ACT_POLL);
  assign do_enc = (item_i.action == rkd_pkg::ACT_ENC) ||
                  (item_i.action == rkd_pkg::ACT_POLL);

  // Hold back a click inside the double-click window (signed view of time)
  assign click_held = (pend_q == rkd_pkg::EV_CLICK) &&
                      (held[rkd_pkg::TimeW-1] || (held < win_ext) ||
                       (!ahead[rkd_pkg::TimeW-1] && (ahead > win_ext)));

  // Key step: press stores time, release classifies the hold
  always_comb begin
    pend_k  = pend_q;
    press_d = press_q;
    dmark_d = dmark_q;
    if (do_key) begin
      if (!item_i.key_level) begin
        dmark_d = (held < win_ext);
        press_d = item_i.now_ms;
      end else begin
        if (held > long_ext) begin
          pend_k = rkd_pkg::EV_LONG;
        end else if (held > min_ext) begin
          pend_k = dmark_q ? rkd_pkg::EV_DOUBLE : rkd_pkg::EV_CLICK;
        end
        dmark_d = 1'b0;
      end
    end
  end

  // Encoder step after the key step, then read handling
  always_comb begin
    pend_d  = pend_k;
    phase_d = phase_q;
    res     = rkd_pkg::EV_NONE;
    if (do_enc) begin
      if (phase_q == rkd_pkg::PHASE_IDLE) begin
        if (!item_i.a_level) begin
          phase_d = item_i.b_level ? rkd_pkg::PHASE_B_HI : rkd_pkg::PHASE_B_LO;
        end
      end else begin
        if (item_i.a_level) begin
          if ((phase_q == rkd_pkg::PHASE_B_HI) && !item_i.b_level) begin
            pend_d = rkd_pkg::EV_RIGHT;
          end else if ((phase_q == rkd_pkg::PHASE_B_LO) && item_i.b_level) begin
            pend_d = rkd_pkg::EV_LEFT;
          end
        end
        phase_d = rkd_pkg::PHASE_IDLE;
      end
    end
    if ((item_i.action == rkd_pkg::ACT_READ) && !click_held) begin
      res    = pend_q;
      pend_d = rkd_pkg::EV_NONE;
    end
  end

  // Commit state only when a transaction moves through
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= rkd_pkg::EV_NONE;
      press_q <= '0;
      dmark_q <= 1'b0;
      phase_q <= rkd_pkg::PHASE_IDLE;
    end else if (step_i) begin
      pend_q  <= pend_d;
      press_q <= press_d;
      dmark_q <= dmark_d;
      phase_q <= phase_d;
    end
  end

  assign event_o = res;

  // Phase three is never entered
  `RKD_ASSERT_NEVER(a_phase_three, clk_i, rst_ni, phase_q == rkd_pkg::PHASE_SPARE)
  // A release always clears the double-click mark
  `RKD_ASSERT(a_release_clears, clk_i, rst_ni,
              (step_i && do_key && item_i.key_level) |=> !dmark_q)
  // Only a read produces a nonzero event
  `RKD_ASSERT(a_event_on_read, clk_i, rst_ni,
              (event_o != rkd_pkg::EV_NONE) |-> (item_i.action == rkd_pkg::ACT_READ))

endmodule

[design/rotary_knob_key_event_decoder.sv]
// ----------------------------------------------------------------------------
// rotary_knob_key_event_decoder
// Push key and rotary encoder event decoder with valid/stall channels.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one transaction: an
//   action (key edge, encoder A edge, poll, read), a millisecond tick and the
//   key, A and B pin levels. The output channel (out_valid_o / out_stall_i)
//   returns exactly one event code per input transaction; it is nonzero only
//   for a read that finds a deliverable event.
//   From input acceptance, a transaction passes one input register, then the
//   decode into the result register. Throughput is one transaction per cycle
//   while out_stall_i is low; the decode is a single pass of two 32-bit
//   subtractions and a few compares against the timing registers.
//   While the result register holds an unaccepted result and out_stall_i is
//   high, the input register cannot advance, and in_stall_o rises only when
//   that input register is also full.
//   Reset clears the pending event, press time, double-click mark, encoder
//   phase and both channel valids, and loads the timing registers with
//   450 ms, 1500 ms and 15 ms. Write configuration only while idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rotary_knob_key_event_decoder (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration write port
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_idx_i,
  input  logic [rkd_pkg::CfgW-1:0] cfg_wdata_i,
  // input channel
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               action_i,
  input  logic [rkd_pkg::TimeW-1:0] now_ms_i,
  input  logic                     key_level_i,
  input  logic                     a_level_i,
  input  logic                     b_level_i,
  // output channel
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [2:0]               event_res_o
);

  rkd_pkg::rkd_cfg_t    cfg;
  rkd_pkg::rkd_item_t   item_q, item_d;
  logic                 s1_valid_q, s1_valid_d;
  logic                 out_valid_q, out_valid_d;
  logic [2:0]           event_q, event_d;
  rkd_pkg::rkd_event_e  core_event;
  logic                 in_accept;
  logic                 s1_adv;
  logic                 out_busy;

  rkd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Handshake: result register parts the two sides
  assign out_busy   = out_valid_q && out_stall_i;
  assign s1_adv     = s1_valid_q && !out_busy;
  assign in_stall_o = s1_valid_q && out_busy;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Input register
  always_comb begin
    item_d           = item_q;
    if (in_accept) begin
      item_d.action    = rkd_pkg::rkd_action_e'(action_i);
      item_d.now_ms    = now_ms_i;
      item_d.key_level = key_level_i;
      item_d.a_level   = a_level_i;
      item_d.b_level   = b_level_i;
    end
  end

  assign s1_valid_d  = in_accept || (s1_valid_q && !s1_adv);
  assign out_valid_d = s1_adv || out_busy;
  assign event_d     = s1_adv ? 3'(core_event) : event_q;

  rkd_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (s1_adv),
    .item_i  (item_q),
    .cfg_i   (cfg),
    .event_o (core_event)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    event_q <= event_d;
  end

  assign out_valid_o = out_valid_q;
  assign event_res_o = event_q;

  // Input stalls only when both registers are full and the output is held
  `RKD_ASSERT(a_stall_cause, clk_i, rst_ni,
              in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
  // An accepted transaction lands in the input register
  `RKD_ASSERT(a_accept_lands, clk_i, rst_ni, in_accept |=> s1_valid_q)
  // A free output takes the waiting transaction next cycle
  `RKD_ASSERT(a_adv_to_out, clk_i, rst_ni, s1_adv |=> out_valid_q)

endmodule
